// ===== rtl/core/rsie_pkg.sv =====
// Shared types, instruction codes and the shifter for the instruction executor.
// No dependencies; used by risc_subset_instruction_executor.
package rsie_pkg;

  localparam logic [23:0] BX_PATTERN     = 24'h12FFF1;
  localparam logic [2:0]  BRANCH_PATTERN = 3'b101;
  localparam logic [3:0]  MUL_PATTERN    = 4'b1001;

  localparam logic [1:0] DP_DATA = 2'b00;
  localparam logic [1:0] DP_MEM  = 2'b01;

  localparam logic [3:0] OP_AND = 4'b0000;
  localparam logic [3:0] OP_SUB = 4'b0010;
  localparam logic [3:0] OP_RSB = 4'b0011;
  localparam logic [3:0] OP_ADD = 4'b0100;
  localparam logic [3:0] OP_CMP = 4'b1010;
  localparam logic [3:0] OP_MOV = 4'b1101;

  localparam logic [3:0] COND_EQ = 4'b0000;
  localparam logic [3:0] COND_NE = 4'b0001;
  localparam logic [3:0] COND_GE = 4'b1010;
  localparam logic [3:0] COND_LT = 4'b1011;
  localparam logic [3:0] COND_GT = 4'b1100;
  localparam logic [3:0] COND_LE = 4'b1101;
  localparam logic [3:0] COND_AL = 4'b1110;

  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;

  localparam logic [3:0] REG_SP = 4'd13;
  localparam logic [3:0] REG_LR = 4'd14;
  localparam logic [3:0] REG_PC = 4'd15;

  localparam logic [2:0] CFG_START = 3'd0;
  localparam logic [2:0] CFG_STACK = 3'd1;
  localparam logic [2:0] CFG_ARG0  = 3'd2;
  localparam logic [2:0] CFG_ARG1  = 3'd3;
  localparam logic [2:0] CFG_ARG2  = 3'd4;
  localparam logic [2:0] CFG_ARG3  = 3'd5;

  typedef enum logic [1:0] {
    CLASS_DATA   = 2'd0,
    CLASS_MEM    = 2'd1,
    CLASS_BRANCH = 2'd2,
    CLASS_OTHER  = 2'd3
  } iclass_e;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic        illegal;
    iclass_e     iclass;
    logic        branch_taken;
    logic        reg_written;
    logic [3:0]  written_index;
    logic [31:0] written_value;
    logic        stored;
    logic [31:0] store_address;
    logic [31:0] store_value;
    logic        store_is_byte;
  } result_t;

  // zero amount passes through; register amounts of 32+ saturate, ROR wraps
  function automatic logic [31:0] shift_val(logic [31:0] v, logic [1:0] st,
                                            logic [31:0] amt);
    logic [4:0]  a5;
    logic        big;
    logic [31:0] r;
    a5  = amt[4:0];
    big = |amt[31:5];
    r   = v;
    if (amt != 32'd0) begin
      case (st)
        SH_LSL:  r = big ? 32'd0 : (v << a5);
        SH_LSR:  r = big ? 32'd0 : (v >> a5);
        SH_ASR:  r = big ? {32{v[31]}} : 32'($signed(v) >>> a5);
        default: r = 32'({v, v} >> a5);
      endcase
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/rsie_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module rsie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/risc_subset_instruction_executor.sv =====
// Top level of the subset instruction executor: decode, execute, memory pipe.
// Depends on rsie_pkg and rsie_ram.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+----------------------------------
//  in      | input     | in_valid_i / in_stall_o   | action_i, instruction_i
//  out     | output    | out_valid_o / out_stall_i | next_pc_o .. store_is_byte_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  Pipeline: register-file read on the accepting edge, execute in the next cycle.
//  ALU, branch and CMP words retire straight from execute, so one word per cycle
//  flows while the result register is free. Loads and stores go through execute,
//  reciprocal multiply for the word index, memory access, writeback; no word
//  is taken meanwhile. Reset and every restart run a clearing pass over the
//  data memory; input is stalled throughout, configuration writes still land.
//  The result register takes a new word while out_stall_i is low or it is empty.
module risc_subset_instruction_executor #(
  parameter int MEM_WORDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] instruction_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] next_pc_o,
  output logic        halted_o,
  output logic        illegal_o,
  output logic [1:0]  instr_class_o,
  output logic        branch_taken_o,
  output logic        reg_written_o,
  output logic [3:0]  written_index_o,
  output logic [31:0] written_value_o,
  output logic        stored_o,
  output logic [31:0] store_address_o,
  output logic [31:0] store_value_o,
  output logic        store_is_byte_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int AW  = $clog2(MEM_WORDS);
  localparam int KSH = 30 + AW;
  // floor(2^KSH / MEM_WORDS): quotient estimate is low by at most one
  localparam logic [30:0] RECIP = 31'((64'd1 << KSH) / 64'(MEM_WORDS));

  // ---------------- configuration ----------------
  logic [31:0] cfg_q [6];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) cfg_q[i] <= 32'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rsie_pkg::CFG_START: cfg_q[0] <= cfg_data_i;
        rsie_pkg::CFG_STACK: cfg_q[1] <= cfg_data_i;
        rsie_pkg::CFG_ARG0:  cfg_q[2] <= cfg_data_i;
        rsie_pkg::CFG_ARG1:  cfg_q[3] <= cfg_data_i;
        rsie_pkg::CFG_ARG2:  cfg_q[4] <= cfg_data_i;
        rsie_pkg::CFG_ARG3:  cfg_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- architectural state ----------------
  logic [31:0] pc_q;
  logic [31:0] cmp_q;
  logic [15:0] rvalid_q;       // entry holds a written value
  logic [31:0] snap_q [5];     // r0..r3, sp as loaded by the last restart
  logic        clr_q;
  logic [AW-1:0] clr_idx_q;

  // forwarding of the write that landed on the accepting edge
  logic        fwd_v_q;
  logic [3:0]  fwd_idx_q;
  logic [31:0] fwd_val_q;

  // ---------------- pipeline registers ----------------
  logic        ex_v_q, ex_act_q;
  logic [31:0] ex_iw_q;
  logic [3:0]  ex_xidx_q;
  logic        m1_v_q, m2_v_q, m3_v_q;
  logic [31:0] m_addr_q, m_sval_q;
  logic        m_load_q, m_byte_q;
  logic [3:0]  m_rd_q;
  logic [29:0] m_quot_q;

  logic        out_v_q;
  rsie_pkg::result_t out_q;

  logic out_free, accept;
  assign out_free = !out_v_q || !out_stall_i;

  // ---------------- register file: three read copies ----------------
  logic        rf_we;
  logic [3:0]  rf_widx;
  logic [31:0] rf_wval;
  logic [3:0]  xidx_in;
  logic [31:0] rd_n, rd_m, rd_x;

  assign xidx_in = (instruction_i[27:26] == rsie_pkg::DP_MEM && !instruction_i[20])
                   ? instruction_i[15:12] : instruction_i[11:8];

  rsie_ram #(.WIDTH(32), .DEPTH(16)) u_rf_n (
    .clk_i, .we_i(rf_we), .waddr_i(rf_widx), .wdata_i(rf_wval),
    .re_i(accept), .raddr_i(instruction_i[19:16]), .rdata_o(rd_n));
  rsie_ram #(.WIDTH(32), .DEPTH(16)) u_rf_m (
    .clk_i, .we_i(rf_we), .waddr_i(rf_widx), .wdata_i(rf_wval),
    .re_i(accept), .raddr_i(instruction_i[3:0]), .rdata_o(rd_m));
  rsie_ram #(.WIDTH(32), .DEPTH(16)) u_rf_x (
    .clk_i, .we_i(rf_we), .waddr_i(rf_widx), .wdata_i(rf_wval),
    .re_i(accept), .raddr_i(xidx_in), .rdata_o(rd_x));

  function automatic logic [31:0] pick(logic [3:0] idx, logic [31:0] ram);
    logic [31:0] r;
    r = 32'd0;
    if (idx == rsie_pkg::REG_PC) begin
      r = pc_q;
    end else if (rvalid_q[idx]) begin
      r = (fwd_v_q && fwd_idx_q == idx) ? fwd_val_q : ram;
    end else begin
      case (idx)
        4'd0:             r = snap_q[0];
        4'd1:             r = snap_q[1];
        4'd2:             r = snap_q[2];
        4'd3:             r = snap_q[3];
        rsie_pkg::REG_SP: r = snap_q[4];
        default:          r = 32'd0;
      endcase
    end
    return r;
  endfunction

  // ---------------- execute ----------------
  logic [3:0]  rn, rd, rm;
  logic [31:0] rn_v, rm_v, rx_v, op2, shv, alu, mem_off;
  logic        ex_restart, ex_mem, ex_wr, ex_cmp_we;
  logic [3:0]  ex_widx;
  logic [31:0] ex_pc_d, ex_cmp_d;
  rsie_pkg::result_t ex_res;
  logic        put_en;
  logic [3:0]  put_idx;
  logic [31:0] put_val;
  logic        cond;
  logic signed [31:0] cmp_s;

  assign rn   = ex_iw_q[19:16];
  assign rd   = ex_iw_q[15:12];
  assign rm   = ex_iw_q[3:0];

  // operand fetch also follows pc_q, snapshot and forwarding state
  always_comb begin
    rn_v = pick(rn, rd_n);
    rm_v = pick(rm, rd_m);
    rx_v = pick(ex_xidx_q, rd_x);
  end

  assign op2  = ex_iw_q[25] ? {24'd0, ex_iw_q[7:0]} : rm_v;
  assign cmp_s = $signed(cmp_q);

  always_comb begin
    case (ex_iw_q[31:28])
      rsie_pkg::COND_AL: cond = 1'b1;
      rsie_pkg::COND_EQ: cond = (cmp_s == 0);
      rsie_pkg::COND_NE: cond = (cmp_s != 0);
      rsie_pkg::COND_GT: cond = (cmp_s > 0);
      rsie_pkg::COND_GE: cond = (cmp_s >= 0);
      rsie_pkg::COND_LT: cond = (cmp_s < 0);
      rsie_pkg::COND_LE: cond = (cmp_s <= 0);
      default:           cond = 1'b0;
    endcase
  end

  // immediate shift, or register shift for MOV with bit 4 set
  always_comb begin
    if (ex_iw_q[24:21] == rsie_pkg::OP_MOV && ex_iw_q[4] && ex_iw_q[26] == 1'b0) begin
      shv = rsie_pkg::shift_val(rm_v, ex_iw_q[6:5], rx_v);
    end else begin
      shv = rsie_pkg::shift_val(rm_v, ex_iw_q[6:5], {27'd0, ex_iw_q[11:7]});
    end
  end

  always_comb begin
    logic [3:0] op;
    logic [1:0] dp;
    logic       sh_used;
    op      = ex_iw_q[24:21];
    dp      = ex_iw_q[27:26];
    sh_used = !ex_iw_q[25] && (ex_iw_q[11:4] != 8'd0);
    ex_restart = !ex_act_q;
    ex_mem     = 1'b0;
    ex_cmp_we  = 1'b0;
    ex_cmp_d   = rn_v - op2;
    put_en     = 1'b0;
    put_idx    = rd;
    alu        = 32'd0;
    ex_pc_d    = pc_q + 32'd4;
    ex_res     = '0;
    ex_res.iclass = rsie_pkg::CLASS_DATA;
    mem_off    = ex_iw_q[25] ? (ex_iw_q[11:4] != 8'd0 ? shv : rm_v)
                             : {20'd0, ex_iw_q[11:0]};
    if (ex_restart) begin
      ex_pc_d       = cfg_q[0];
      ex_res.iclass = rsie_pkg::CLASS_OTHER;
    end else if (ex_iw_q[27:4] == rsie_pkg::BX_PATTERN) begin
      ex_pc_d             = rm_v;
      ex_res.iclass       = rsie_pkg::CLASS_BRANCH;
      ex_res.branch_taken = 1'b1;
    end else if (ex_iw_q[27:25] == rsie_pkg::BRANCH_PATTERN) begin
      ex_res.iclass = rsie_pkg::CLASS_BRANCH;
      if (ex_iw_q[24]) begin
        ex_pc_d             = pc_q + 32'd8 + {{6{ex_iw_q[23]}}, ex_iw_q[23:0], 2'b00};
        ex_res.branch_taken = 1'b1;
        ex_res.reg_written  = 1'b1;
        ex_res.written_index = rsie_pkg::REG_LR;
        ex_res.written_value = pc_q + 32'd4;
      end else if (cond) begin
        ex_pc_d             = pc_q + 32'd8 + {{6{ex_iw_q[23]}}, ex_iw_q[23:0], 2'b00};
        ex_res.branch_taken = 1'b1;
      end
    end else if (dp == rsie_pkg::DP_DATA && op == rsie_pkg::OP_ADD) begin
      put_en = 1'b1;
      alu    = rn_v + (sh_used ? shv : op2);
    end else if (dp == rsie_pkg::DP_DATA && op == rsie_pkg::OP_MOV) begin
      put_en = 1'b1;
      alu    = sh_used ? shv : op2;
    end else if (dp == rsie_pkg::DP_DATA && op == rsie_pkg::OP_SUB) begin
      put_en = 1'b1;
      alu    = rn_v - op2;
    end else if (ex_iw_q[27:22] == 6'd0 && ex_iw_q[7:4] == rsie_pkg::MUL_PATTERN) begin
      put_en  = 1'b1;
      put_idx = rn;
      alu     = rm_v * rx_v;
    end else if (dp == rsie_pkg::DP_DATA && op == rsie_pkg::OP_CMP) begin
      ex_cmp_we = 1'b1;
    end else if (dp == rsie_pkg::DP_DATA && op == rsie_pkg::OP_RSB) begin
      put_en = 1'b1;
      alu    = op2 - rn_v;
    end else if (dp == rsie_pkg::DP_DATA && op == rsie_pkg::OP_AND) begin
      put_en = 1'b1;
      alu    = rn_v & op2;
    end else if (dp == rsie_pkg::DP_MEM) begin
      ex_mem = 1'b1;
    end else begin
      ex_pc_d        = pc_q;
      ex_res.illegal = 1'b1;
      ex_res.iclass  = rsie_pkg::CLASS_OTHER;
    end
    put_val = alu;
    if (put_en) begin
      if (put_idx == rsie_pkg::REG_PC) begin
        ex_pc_d = put_val;
      end else begin
        ex_res.reg_written   = 1'b1;
        ex_res.written_index = put_idx;
        ex_res.written_value = put_val;
      end
    end
    ex_wr   = ex_res.reg_written;
    ex_widx = ex_res.written_index;
    ex_res.next_pc = ex_pc_d;
    ex_res.halted  = (ex_pc_d == 32'd0);
  end

  logic ex_retire, ex_leave;
  assign ex_retire = ex_v_q && !ex_mem && out_free;   // incl. restart
  assign ex_leave  = ex_v_q && (ex_mem || out_free);

  // ---------------- memory pipe ----------------
  logic [46:0]   prod_qm;
  logic [AW:0]   rem1;
  logic [AW-1:0] widx;
  logic [7:0]    lane_rd [4];
  logic [31:0]   mword, mload;
  logic [1:0]    lane;
  rsie_pkg::result_t m3_res;
  logic          m3_retire;

  assign prod_qm = 47'(m_quot_q) * 47'(MEM_WORDS);
  assign rem1    = (AW+1)'({17'd0, m_addr_q[31:2]} - prod_qm);
  assign widx    = (rem1 >= (AW+1)'(MEM_WORDS)) ? AW'(rem1 - (AW+1)'(MEM_WORDS)) : AW'(rem1);
  assign lane    = m_addr_q[1:0];

  for (genvar g = 0; g < 4; g++) begin : g_lane
    logic       we;
    logic [7:0] wd;
    assign we = clr_q || (m2_v_q && !m_load_q && (!m_byte_q || lane == 2'(g)));
    assign wd = clr_q ? 8'd0 : (m_byte_q ? m_sval_q[7:0] : m_sval_q[8*g +: 8]);
    rsie_ram #(.WIDTH(8), .DEPTH(MEM_WORDS)) u_dmem (
      .clk_i, .we_i(we), .waddr_i(clr_q ? clr_idx_q : widx), .wdata_i(wd),
      .re_i(m2_v_q && m_load_q), .raddr_i(widx), .rdata_o(lane_rd[g]));
  end

  assign mword = {lane_rd[3], lane_rd[2], lane_rd[1], lane_rd[0]};
  assign mload = m_byte_q ? {24'd0, lane_rd[lane]} : mword;
  assign m3_retire = m3_v_q && out_free;

  always_comb begin
    m3_res        = '0;
    m3_res.iclass = rsie_pkg::CLASS_MEM;
    m3_res.next_pc = pc_q + 32'd4;
    if (m_load_q) begin
      if (m_rd_q == rsie_pkg::REG_PC) begin
        m3_res.next_pc = mload;
      end else begin
        m3_res.reg_written   = 1'b1;
        m3_res.written_index = m_rd_q;
        m3_res.written_value = mload;
      end
    end else begin
      m3_res.stored        = 1'b1;
      m3_res.store_address = m_addr_q;
      m3_res.store_value   = m_sval_q;
      m3_res.store_is_byte = m_byte_q;
    end
    m3_res.halted = (m3_res.next_pc == 32'd0);
  end

  // ---------------- register file write ----------------
  assign rf_we   = (ex_retire && !ex_restart && ex_wr) || (m3_retire && m3_res.reg_written);
  assign rf_widx = m3_v_q ? m3_res.written_index : ex_widx;
  assign rf_wval = m3_v_q ? m3_res.written_value : ex_res.written_value;

  // ---------------- input handshake ----------------
  assign in_stall_o = clr_q || m1_v_q || m2_v_q || m3_v_q
                      || (ex_v_q && (ex_mem || ex_restart || !out_free));
  assign accept = in_valid_i && !in_stall_o;

  // ---------------- sequential ----------------
  logic ex_v_d;
  assign ex_v_d = accept ? 1'b1 : (ex_leave ? 1'b0 : ex_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_v_q    <= 1'b0;
      m1_v_q    <= 1'b0;
      m2_v_q    <= 1'b0;
      m3_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
      pc_q      <= 32'd0;
      cmp_q     <= 32'd0;
      rvalid_q  <= 16'd0;
      for (int i = 0; i < 5; i++) snap_q[i] <= 32'd0;
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
      fwd_v_q   <= 1'b0;
    end else begin
      ex_v_q  <= ex_v_d;
      m1_v_q  <= ex_v_q && ex_mem;
      m2_v_q  <= m1_v_q;
      m3_v_q  <= m3_v_q ? !out_free : m2_v_q;
      // held with the word in execute, which may wait on the result register
      if (accept) begin
        fwd_v_q <= rf_we;
      end
      if (ex_retire || m3_retire) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
      if (rf_we) begin
        rvalid_q[rf_widx] <= 1'b1;
      end
      if (m3_retire) begin
        pc_q <= m3_res.next_pc;
      end
      if (ex_retire) begin
        pc_q <= ex_pc_d;
        if (ex_cmp_we) cmp_q <= ex_cmp_d;
        if (ex_restart) begin
          cmp_q     <= 32'd0;
          rvalid_q  <= 16'd0;
          snap_q[0] <= cfg_q[2];
          snap_q[1] <= cfg_q[3];
          snap_q[2] <= cfg_q[4];
          snap_q[3] <= cfg_q[5];
          snap_q[4] <= cfg_q[1];
          clr_q     <= 1'b1;
          clr_idx_q <= '0;
        end
      end
      if (clr_q) begin
        if (clr_idx_q == AW'(MEM_WORDS - 1)) begin
          clr_q <= 1'b0;
        end else begin
          clr_idx_q <= clr_idx_q + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_idx_q <= rf_widx;
      fwd_val_q <= rf_wval;
      ex_act_q  <= action_i;
      ex_iw_q   <= instruction_i;
      ex_xidx_q <= xidx_in;
    end
    if (ex_v_q && ex_mem) begin
      m_addr_q <= rn_v + mem_off;
      m_sval_q <= rx_v;
      m_load_q <= ex_iw_q[20];
      m_byte_q <= ex_iw_q[22];
      m_rd_q   <= rd;
    end
    if (m1_v_q) begin
      m_quot_q <= 30'((61'(m_addr_q[31:2]) * 61'(RECIP)) >> KSH);
    end
    if (ex_retire) begin
      out_q <= ex_res;
    end else if (m3_retire) begin
      out_q <= m3_res;
    end
  end

  // ---------------- outputs ----------------
  assign out_valid_o     = out_v_q;
  assign next_pc_o       = out_q.next_pc;
  assign halted_o        = out_q.halted;
  assign illegal_o       = out_q.illegal;
  assign instr_class_o   = out_q.iclass;
  assign branch_taken_o  = out_q.branch_taken;
  assign reg_written_o   = out_q.reg_written;
  assign written_index_o = out_q.written_index;
  assign written_value_o = out_q.written_value;
  assign stored_o        = out_q.stored;
  assign store_address_o = out_q.store_address;
  assign store_value_o   = out_q.store_value;
  assign store_is_byte_o = out_q.store_is_byte;

endmodule
